// ===== rtl/core/tsaq_pkg.sv =====
// Shared constants, types and tables for the tilt smoothing and quaternion block.
package tsaq_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_COUNT   = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam int CNT_W        = $clog2(ATAN_COUNT);

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [50:0] PI_Q13      = 51'sd25736;

  localparam int CTRL_W  = 16;
  localparam int STATE_W = 24;
  localparam int OUT_W   = 7 * 16;

  typedef enum logic [2:0] {
    REG_ALPHA  = 3'd0,
    REG_ANG_LO = 3'd1,
    REG_ANG_HI = 3'd2,
    REG_AXIS_X = 3'd3,
    REG_AXIS_Y = 3'd4,
    REG_AXIS_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [0:0] {
    FUNC_UPDATE = 1'b0,
    FUNC_PRESET = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FA,
    ST_FB,
    ST_FSUM,
    ST_AMUL,
    ST_ANG,
    ST_CORD,
    ST_QX,
    ST_QY,
    ST_QZ,
    ST_QW,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic in_ready;
    logic acc_load;
    logic state_load;
    logic angle_load;
    logic qx_load;
    logic qy_load;
    logic qzw_load;
    logic out_load;
  } seq_ctrl_t;

  // atan(2^-i) in 2^-28 rad
  function automatic logic [27:0] atan_lut(input logic [CNT_W-1:0] idx);
    logic [27:0] r;
    case (idx)
      5'd0:    r = 28'd210828714;
      5'd1:    r = 28'd124459457;
      5'd2:    r = 28'd65760959;
      5'd3:    r = 28'd33381290;
      5'd4:    r = 28'd16755422;
      5'd5:    r = 28'd8385879;
      5'd6:    r = 28'd4193963;
      5'd7:    r = 28'd2097109;
      5'd8:    r = 28'd1048571;
      5'd9:    r = 28'd524287;
      5'd10:   r = 28'd262144;
      5'd11:   r = 28'd131072;
      5'd12:   r = 28'd65536;
      5'd13:   r = 28'd32768;
      5'd14:   r = 28'd16384;
      5'd15:   r = 28'd8192;
      5'd16:   r = 28'd4096;
      5'd17:   r = 28'd2048;
      5'd18:   r = 28'd1024;
      5'd19:   r = 28'd512;
      5'd20:   r = 28'd256;
      5'd21:   r = 28'd128;
      5'd22:   r = 28'd64;
      5'd23:   r = 28'd32;
      default: r = 28'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [50:0] v);
    logic [15:0] r;
    if (v > 51'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -51'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tilt_smoothing_angle_quaternion.sv =====
// Top level: low-pass smoothing, angle map and axis-angle quaternion of a tilt actuator.
// An update word passes through the filter blend and the angle map (states FA, FB, FSUM,
// AMUL and ANG), with three passes through the one shared 33x18 multiplier. The CORDIC
// then runs one iteration per cycle on the half angle and raises a registered done flag.
// States QX, QY, QZ and QW form the three axis products and the scalar part, and ST_OUT
// loads the output register. That load waits while an earlier result still sits
// unaccepted in the output register. s_axis_tready is low for that whole time and rises
// the cycle after the load, so an update word is not taken before the last one is loaded.
// A finished result may wait in the output register while the next word is taken.
// A preset word loads the filter state in its acceptance cycle and gives no result.
// Configuration is taken on any cycle.
module tilt_smoothing_angle_quaternion
  import tsaq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // control
  input  logic [0:0]          s_axis_tuser,   // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata,   // control_echo, smoothed_control, tilt_angle,
                                              // quat_w, quat_x, quat_y, quat_z
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  seq_state_e state_q, state_d;
  seq_ctrl_t  ctl;

  logic [14:0]         alpha_q;
  logic signed [15:0]  ang_lo_q, ang_hi_q, axis_x_q, axis_y_q, axis_z_q;
  logic signed [STATE_W-1:0] smooth_q;
  logic signed [CTRL_W-1:0]  ctrl_q;
  logic signed [50:0]  prod_q, acc_q;
  logic signed [32:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic [15:0]         angle_q, qw_q, qx_q, qy_q, qz_q;
  logic                out_valid_q;
  logic [OUT_W-1:0]    out_data_q;

  logic                in_fire;
  logic signed [23:0]  c22;
  logic signed [17:0]  beta;
  logic signed [16:0]  diff;
  logic signed [50:0]  fsum, fsh, asum, aval, xr, yr, sr;
  logic signed [STATE_W-1:0] smooth_new;
  logic [15:0]         angle_sat;
  logic                cordic_done;
  logic signed [33:0]  cx, cy;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign c22         = {ctrl_q, 8'b0};
  assign beta        = 18'sd32768 - signed'({3'b0, alpha_q});
  assign diff        = 17'(ang_hi_q) - 17'(ang_lo_q);

  // filter blend, round half up, hold within state range
  assign fsum = acc_q + prod_q + 51'sd16384;
  assign fsh  = fsum >>> 15;
  always_comb begin
    if (fsh > 51'sd8388607) begin
      smooth_new = 24'sh7FFFFF;
    end else if (fsh < -51'sd8388608) begin
      smooth_new = -24'sh800000;
    end else begin
      smooth_new = fsh[23:0];
    end
  end

  // angle map, saturate to plus or minus pi
  assign asum = prod_q + (51'sd1 <<< 21);
  assign aval = (asum >>> 22) + 51'(ang_lo_q);
  always_comb begin
    if (aval > PI_Q13) begin
      angle_sat = PI_Q13[15:0];
    end else if (aval < -PI_Q13) begin
      angle_sat = 16'((-PI_Q13));
    end else begin
      angle_sat = aval[15:0];
    end
  end

  assign xr = (51'(cx) + 51'sd16384) >>> 15;
  assign yr = (prod_q + (51'sd1 <<< 29)) >>> 30;
  assign sr = (51'(smooth_q) + 51'sd128) >>> 8;

  tsaq_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.angle_load),
    .angle_i (signed'(angle_sat)),
    .done_o  (cordic_done),
    .x_o     (cx),
    .y_o     (cy)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (func_e'(s_axis_tuser[0]) == FUNC_UPDATE)) begin
          state_d = ST_FA;
        end
      end
      ST_FA:   state_d = ST_FB;
      ST_FB:   state_d = ST_FSUM;
      ST_FSUM: state_d = ST_AMUL;
      ST_AMUL: state_d = ST_ANG;
      ST_ANG:  state_d = ST_CORD;
      ST_CORD: begin
        if (cordic_done) begin
          state_d = ST_QX;
        end
      end
      ST_QX:   state_d = ST_QY;
      ST_QY:   state_d = ST_QZ;
      ST_QZ:   state_d = ST_QW;
      ST_QW:   state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl   = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_FA: begin
        mul_a = 33'(smooth_q);
        mul_b = signed'({3'b0, alpha_q});
      end
      ST_FB: begin
        mul_a        = 33'(c22);
        mul_b        = beta;
        ctl.acc_load = 1'b1;
      end
      ST_FSUM: ctl.state_load = 1'b1;
      ST_AMUL: begin
        mul_a = 33'(smooth_q);
        mul_b = 18'(diff);
      end
      ST_ANG:  ctl.angle_load = 1'b1;
      ST_CORD: ;
      ST_QX: begin
        mul_a = cy[32:0];
        mul_b = 18'(axis_x_q);
      end
      ST_QY: begin
        mul_a       = cy[32:0];
        mul_b       = 18'(axis_y_q);
        ctl.qx_load = 1'b1;
      end
      ST_QZ: begin
        mul_a       = cy[32:0];
        mul_b       = 18'(axis_z_q);
        ctl.qy_load = 1'b1;
      end
      ST_QW:  ctl.qzw_load = 1'b1;
      ST_OUT: ctl.out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign s_axis_tready = ctl.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      smooth_q    <= '0;
      alpha_q     <= '0;
      ang_lo_q    <= '0;
      ang_hi_q    <= 16'sd12868;
      axis_x_q    <= 16'sd32767;
      axis_y_q    <= '0;
      axis_z_q    <= '0;
    end else begin
      state_q <= state_d;
      if (ctl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && (func_e'(s_axis_tuser[0]) == FUNC_PRESET)) begin
        smooth_q <= {signed'(s_axis_tdata), 8'b0};
      end else if (ctl.state_load) begin
        smooth_q <= smooth_new;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ALPHA:  alpha_q  <= cfg_data_i[14:0];
          REG_ANG_LO: ang_lo_q <= cfg_data_i;
          REG_ANG_HI: ang_hi_q <= cfg_data_i;
          REG_AXIS_X: axis_x_q <= cfg_data_i;
          REG_AXIS_Y: axis_y_q <= cfg_data_i;
          REG_AXIS_Z: axis_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_fire) begin
      ctrl_q <= s_axis_tdata;
    end
    if (ctl.acc_load) begin
      acc_q <= prod_q;
    end
    if (ctl.angle_load) begin
      angle_q <= angle_sat;
    end
    if (ctl.qx_load) begin
      qx_q <= sat16(yr);
    end
    if (ctl.qy_load) begin
      qy_q <= sat16(yr);
    end
    if (ctl.qzw_load) begin
      qz_q <= sat16(yr);
      qw_q <= sat16(xr);
    end
    if (ctl.out_load) begin
      out_data_q <= {qz_q, qy_q, qx_q, qw_q, angle_q, sat16(sr), ctrl_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_preset_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> s_axis_tready)
    else $error("preset word left the block busy");

  a_update_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> !s_axis_tready)
    else $error("update word did not start the sequence");

  a_cordic_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> state_q == ST_CORD)
    else $error("cordic finished outside its wait state");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT)
    else $error("result word appeared without a load");

endmodule

// ===== rtl/core/tsaq_cordic.sv =====
// Iterative rotation-mode CORDIC giving cos and sin of the half tilt angle.
module tsaq_cordic
  import tsaq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  angle_i,
  output logic                done_o,
  output logic signed [33:0]  x_o,
  output logic signed [33:0]  y_o
);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [31:0] z_q, z_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic signed [33:0] sx, sy;
  logic signed [31:0] at;
  logic               last;

  assign sx   = x_q >>> cnt_q;
  assign sy   = y_q >>> cnt_q;
  assign at   = signed'({4'b0, atan_lut(cnt_q)});
  assign last = (cnt_q == CNT_W'(CORDIC_ITERS - 1));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d   = CORDIC_GAIN;
      y_d   = '0;
      z_d   = {{2{angle_i[15]}}, angle_i, 14'b0};
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!z_q[31]) begin
        x_d = x_q - sy;
        y_d = y_q + sx;
        z_d = z_q - at;
      end else begin
        x_d = x_q + sy;
        y_d = y_q - sx;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the tilt smoothing, angle map and quaternion block.
module testbench;
  import tsaq_pkg::*;

  localparam int RESULT_HOLD = 48;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 136;
  localparam int PLAN_LEN    = 36;

  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_w;
    logic signed [15:0] tilt_angle;
    logic signed [15:0] smoothed_control;
    logic signed [15:0] control_echo;
  } tilt_word_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    func_e              func;
    logic [2:0]         idx;
    logic [15:0]        val;
    logic               known;
    logic signed [15:0] echo;
    logic signed [15:0] smooth;
    logic signed [15:0] angle;
  } plan_row_t;

  localparam plan_row_t SETUP_PLAN [0:PLAN_LEN-1] = '{
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h0000, 1'b1, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h4000, 1'b1, 16'sd16384, 16'sd16384, 16'sd12868},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h7FFF, 1'b1, 16'sd32767, 16'sd32767, 16'sd25735},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h8000, 1'b1, -16'sd32768, -16'sd32768, -16'sd25736},
    '{ROW_WORD, FUNC_PRESET, '0, 16'h4000, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h4000, 1'b1, 16'sd16384, 16'sd16384, 16'sd12868},
    '{ROW_REG,  FUNC_UPDATE, REG_ALPHA,  16'h7FFF, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_ANG_LO, -16'sd25736, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_ANG_HI, 16'sd25736, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_AXIS_X, 16'h8000, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_AXIS_Y, 16'h8000, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_AXIS_Z, 16'h7FFF, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_SPARE_6, 16'hFFFF, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_SPARE_7, 16'h1234, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_PRESET, '0, 16'h7FFF, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h8000, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h7FFF, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_PRESET, '0, 16'h8000, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h8000, 1'b1, -16'sd32768, -16'sd32768, -16'sd25736},
    '{ROW_WORD, FUNC_PRESET, '0, 16'h7FFF, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h7FFF, 1'b1, 16'sd32767, 16'sd32767, 16'sd25736},
    '{ROW_REG,  FUNC_UPDATE, REG_ALPHA,  16'h4000, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_ANG_LO, 16'sd25736, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_ANG_HI, -16'sd25736, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_AXIS_X, 16'h0000, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_AXIS_Y, 16'sd23170, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_AXIS_Z, -16'sd23170, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h0000, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h4000, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'hC000, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_PRESET, '0, 16'h2000, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h2000, 1'b1, 16'sd8192, 16'sd8192, 16'sd0},
    '{ROW_REG,  FUNC_UPDATE, REG_ALPHA,  16'h0000, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_ANG_LO, -16'sd25736, 1'b0, '0, '0, '0},
    '{ROW_REG,  FUNC_UPDATE, REG_ANG_HI, -16'sd25736, 1'b0, '0, '0, '0},
    '{ROW_WORD, FUNC_UPDATE, '0, 16'h0001, 1'b1, 16'sd1, 16'sd1, -16'sd25736}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata  = '0;
  logic [0:0]       s_axis_tuser  = FUNC_UPDATE;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [2:0]       cfg_index_i   = '0;
  logic [15:0]      cfg_data_i    = '0;

  logic [14:0]        cf_alpha;
  logic signed [15:0] cf_ang_lo;
  logic signed [15:0] cf_ang_hi;
  logic signed [15:0] cf_axis_x;
  logic signed [15:0] cf_axis_y;
  logic signed [15:0] cf_axis_z;
  logic signed [23:0] filt_state;

  longint half_atan [0:23] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32
  };

  string field_names [0:6] = '{
    "control_echo", "smoothed_control", "tilt_angle",
    "quat_w", "quat_x", "quat_y", "quat_z"
  };

  tilt_word_t due_poses [$];
  tilt_word_t seen_pose;
  tilt_word_t want_pose;

  int n_words;
  int n_presets;
  int n_checked;
  int n_regs;
  int slips;
  int cycles;
  int src_gap_pct;
  int snk_stall_pct;
  bit cfg_open;

  tilt_smoothing_angle_quaternion u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [15:0] q16(input longint v);
    return 16'(clip(v, -32768, 32767));
  endfunction

  task automatic store_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      REG_ALPHA:  cf_alpha  = val[14:0];
      REG_ANG_LO: cf_ang_lo = val;
      REG_ANG_HI: cf_ang_hi = val;
      REG_AXIS_X: cf_axis_x = val;
      REG_AXIS_Y: cf_axis_y = val;
      REG_AXIS_Z: cf_axis_z = val;
      default: ;
    endcase
  endtask

  // blend the control into the filter, map to an angle, rotate by half of it
  function automatic tilt_word_t smooth_and_rotate(input logic signed [15:0] ctrl);
    longint c22, a, sum, lo, ang, x, y, z, nx, ny;
    tilt_word_t r;
    c22 = longint'(ctrl) * 256;
    a = longint'(cf_alpha);
    sum = longint'(filt_state) * a + c22 * (32768 - a);
    filt_state = 24'(clip((sum + 16384) >>> 15, -8388608, 8388607));
    lo = longint'(cf_ang_lo);
    ang = lo + (((longint'(cf_ang_hi) - lo) * longint'(filt_state) + 64'sd2097152) >>> 22);
    ang = clip(ang, -25736, 25736);
    z = ang * 16384;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= half_atan[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += half_atan[i];
      end
      x = nx;
      y = ny;
    end
    r.control_echo     = ctrl;
    r.smoothed_control = q16((longint'(filt_state) + 128) >>> 8);
    r.tilt_angle       = q16(ang);
    r.quat_w           = q16((x + 16384) >>> 15);
    r.quat_x           = q16((longint'(cf_axis_x) * y + 64'sd536870912) >>> 30);
    r.quat_y           = q16((longint'(cf_axis_y) * y + 64'sd536870912) >>> 30);
    r.quat_z           = q16((longint'(cf_axis_z) * y + 64'sd536870912) >>> 30);
    return r;
  endfunction

  task automatic send_word(input func_e f, input logic [15:0] ctrl, input logic known,
                           input logic signed [15:0] k_echo, k_smooth, k_angle);
    tilt_word_t pose;
    if (cfg_open) begin
      cfg_valid_i <= 1'b0;
      cfg_open = 1'b0;
    end
    if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ctrl;
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    n_words++;
    if (f == FUNC_PRESET) begin
      filt_state = {ctrl, 8'h00};
      n_presets++;
    end else begin
      pose = smooth_and_rotate(ctrl);
      if (known) begin
        pose.control_echo     = k_echo;
        pose.smoothed_control = k_smooth;
        pose.tilt_angle       = k_angle;
      end
      due_poses.push_back(pose);
    end
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_open = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    store_reg(idx, val);
    n_regs++;
    @(negedge clk_i);
  endtask

  // hold the source until every pending result is out and the block has settled
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_poses.size() != 0) @(negedge clk_i);
    repeat (RESULT_HOLD) @(negedge clk_i);
  endtask

  function automatic logic [15:0] draw_axis();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] draw_control();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      1, 2:    return 16'($urandom);
      3:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  task automatic shuffle_setup();
    int a, b;
    case ($urandom_range(0, 3))
      0:       write_reg(REG_ALPHA, 16'h0000);
      1:       write_reg(REG_ALPHA, 16'h7FFF);
      2:       write_reg(REG_ALPHA, 16'hFFFF);
      default: write_reg(REG_ALPHA, 16'($urandom));
    endcase
    a = int'($urandom_range(0, 51472)) - 25736;
    b = int'($urandom_range(0, 51472)) - 25736;
    case ($urandom_range(0, 4))
      0, 1: begin
        write_reg(REG_ANG_LO, 16'((a < b) ? a : b));
        write_reg(REG_ANG_HI, 16'((a < b) ? b : a));
      end
      2: begin
        write_reg(REG_ANG_LO, 16'((a < b) ? b : a));
        write_reg(REG_ANG_HI, 16'((a < b) ? a : b));
      end
      3: begin
        write_reg(REG_ANG_LO, -16'sd25736);
        write_reg(REG_ANG_HI, 16'sd25736);
      end
      default: begin
        write_reg(REG_ANG_LO, 16'($urandom));
        write_reg(REG_ANG_HI, 16'($urandom));
      end
    endcase
    write_reg(REG_AXIS_X, draw_axis());
    write_reg(REG_AXIS_Y, draw_axis());
    write_reg(REG_AXIS_Z, draw_axis());
    if ($urandom_range(0, 2) == 0) begin
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
    end
  endtask

  initial begin
    plan_row_t row;
    cf_alpha   = '0;
    cf_ang_lo  = '0;
    cf_ang_hi  = 16'sd12868;
    cf_axis_x  = 16'sd32767;
    cf_axis_y  = '0;
    cf_axis_z  = '0;
    filt_state = '0;
    src_gap_pct   = 20;
    snk_stall_pct = 10;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int k = 0; k < PLAN_LEN; k++) begin
      row = SETUP_PLAN[k];
      if (row.kind == ROW_REG) begin
        if (!cfg_open) drain();
        write_reg(row.idx, row.val);
      end else begin
        send_word(row.func, row.val, row.known, row.echo, row.smooth, row.angle);
      end
    end
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case ($urandom_range(0, 2))
        0:       src_gap_pct = 0;
        1:       src_gap_pct = 10;
        default: src_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       snk_stall_pct = 0;
        1:       snk_stall_pct = 5;
        default: snk_stall_pct = 20;
      endcase
      if (p == RAND_PHASES - 1) begin
        src_gap_pct   = 0;
        snk_stall_pct = 0;
      end
      shuffle_setup();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 2 && n == PHASE_WORDS / 2) drain();
        send_word(($urandom_range(0, 7) == 0) ? FUNC_PRESET : FUNC_UPDATE, draw_control(),
                  1'b0, '0, '0, '0);
      end
    end
    drain();
    $display("%0d words sent (%0d presets), %0d results checked, %0d register writes",
             n_words, n_presets, n_checked, n_regs);
    $display("%0d mismatches, %0d results still outstanding", slips, due_poses.size());
    if (slips == 0 && due_poses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (snk_stall_pct != 0 && $urandom_range(1, 100) <= snk_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_pose = m_axis_tdata;
      n_checked++;
      if (due_poses.size() == 0) begin
        if (slips < 10) $display("result %0d arrived with nothing pending: %h",
                                 n_checked, seen_pose);
        slips++;
      end else begin
        want_pose = due_poses.pop_front();
        for (int f = 0; f < 7; f++) begin
          if (seen_pose[16*f +: 16] !== want_pose[16*f +: 16]) begin
            if (slips < 10) $display("result %0d %s: expected %0d, got %0d", n_checked,
                                     field_names[f], $signed(want_pose[16*f +: 16]),
                                     $signed(seen_pose[16*f +: 16]));
            slips++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results pending", cycles, due_poses.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
